// ===== hdl/circular_fifo_with_pop_last_defines.svh =====
// ----------------------------------------------------------------------------
// circular_fifo_with_pop_last_defines
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_FIFO_WITH_POP_LAST_DEFINES_SVH
`define CIRCULAR_FIFO_WITH_POP_LAST_DEFINES_SVH

// same-cycle implication
`define CFPL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfpl assertion failed");

// next-cycle implication
`define CFPL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfpl assertion failed");

`endif

// ===== hdl/cfpl_pkg.sv =====
// ----------------------------------------------------------------------------
// cfpl_pkg
// types, codes and defaults for the circular fifo with pop-last
// ----------------------------------------------------------------------------
package cfpl_pkg;

    localparam int DATA_W        = 32;
    localparam int DEPTH_W       = 5;
    localparam int MAX_DEPTH_DEF = 16;
    localparam int WORD_BITS_DEF = 32;
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd16;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_READ   = 2'd1,
        ACT_DELETE = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0] status;
        logic       is_full;
        logic       is_empty;
        logic       do_write;
        logic       do_read;
    } ctrl_res_t;

endpackage

// ===== hdl/cfpl_cell.sv =====
// ----------------------------------------------------------------------------
// cfpl_cell
// one storage cell of the ring, with a pass-through read chain
// ----------------------------------------------------------------------------
module cfpl_cell
    import cfpl_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int IDX_W     = 4,
    parameter int CELL_IDX  = 0
)
(
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_idx,
    input  logic [WORD_BITS-1:0] wr_word,
    input  logic [IDX_W-1:0]     rd_idx,
    input  logic [WORD_BITS-1:0] rd_in,
    output logic [WORD_BITS-1:0] rd_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [WORD_BITS-1:0] word_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_idx == MY_IDX))
        begin
            word_reg <= wr_word;
        end
    end

    assign rd_out = (rd_idx == MY_IDX) ? word_reg : rd_in;

endmodule

// ===== hdl/cfpl_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfpl_ctrl
// head and tail pointers, full and empty flags, action decode
// ----------------------------------------------------------------------------
module cfpl_ctrl
    import cfpl_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF,
    parameter int IDX_W     = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [1:0]         action,
    input  logic [DEPTH_W-1:0] depth_cfg,
    output logic [IDX_W-1:0]   head_idx,
    output logic [IDX_W-1:0]   tail_idx,
    output ctrl_res_t          res
);

    localparam int CW = ((IDX_W > DEPTH_W) ? IDX_W : DEPTH_W) + 1;
    localparam logic [CW-1:0] MAX_D = CW'(MAX_DEPTH);
    localparam logic [CW-1:0] ONE   = CW'(1);

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic             full_reg, full_next;
    logic             empty_reg, empty_next;
    logic [CW-1:0]    depth_w;
    logic [CW-1:0]    eff_d;
    logic             ptr_eq;

    function automatic logic [IDX_W-1:0] step_fwd(input logic [IDX_W-1:0] idx,
                                                  input logic [CW-1:0] d);
        logic [CW-1:0] n;
        n = CW'(idx) + ONE;
        return (n >= d) ? '0 : n[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] step_back(input logic [IDX_W-1:0] idx,
                                                   input logic [CW-1:0] d);
        logic [CW-1:0] n;
        n = (idx == '0) ? (d - ONE) : (CW'(idx) - ONE);
        if (n >= d)
        begin
            n = d - ONE;
        end
        return n[IDX_W-1:0];
    endfunction

    assign depth_w = CW'(depth_cfg);
    assign eff_d   = (depth_w == '0) ? ONE : ((depth_w > MAX_D) ? MAX_D : depth_w);
    assign ptr_eq  = (head_reg == tail_reg);

    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        full_next    = full_reg;
        empty_next   = empty_reg;
        res.status   = STAT_DONE;
        res.do_write = 1'b0;
        res.do_read  = 1'b0;
        case (action)
            ACT_WRITE:
            begin
                if (ptr_eq && !empty_reg)
                begin
                    res.status = STAT_FULL;
                end
                else
                begin
                    res.do_write = 1'b1;
                    head_next    = step_fwd(head_reg, eff_d);
                    if (head_next == tail_reg)
                    begin
                        full_next = 1'b1;
                    end
                    empty_next = 1'b0;
                end
            end
            ACT_READ:
            begin
                if (ptr_eq && !full_reg)
                begin
                    res.status = STAT_EMPTY;
                end
                else
                begin
                    res.do_read = 1'b1;
                    tail_next   = step_fwd(tail_reg, eff_d);
                    if (head_reg == tail_next)
                    begin
                        empty_next = 1'b1;
                    end
                    full_next = 1'b0;
                end
            end
            ACT_DELETE:
            begin
                if (ptr_eq && !full_reg)
                begin
                    res.status = STAT_EMPTY;
                end
                else
                begin
                    head_next = step_back(head_reg, eff_d);
                    if (head_next == tail_reg)
                    begin
                        empty_next = 1'b1;
                    end
                    full_next = 1'b0;
                end
            end
            default:
            begin
                res.status = STAT_DONE;
            end
        endcase
        res.is_full  = full_next;
        res.is_empty = empty_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            full_reg  <= 1'b0;
            empty_reg <= 1'b1;
        end
        else if (accept)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            full_reg  <= full_next;
            empty_reg <= empty_next;
        end
    end

    assign head_idx = head_reg;
    assign tail_idx = tail_reg;

endmodule

// ===== hdl/circular_fifo_with_pop_last.sv =====
// ----------------------------------------------------------------------------
// circular_fifo_with_pop_last
// ring fifo over a row of storage cells, with push, pop and delete-last
// result: registered into the output register, or into the skid register while the output is held
// throughput: one item per cycle while the skid register is free, set by the single pointer update per cycle
// a two-deep output buffer keeps input open while one result waits
// reset: pointers zero, empty set, full clear, depth back to 16, store kept
// ----------------------------------------------------------------------------
module circular_fifo_with_pop_last
    import cfpl_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [DEPTH_W-1:0] cfg_wr_data,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [DATA_W-1:0]  s_axis_tdata,   // write_data
    input  logic [1:0]         s_axis_tuser,   // action
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [DATA_W-1:0]  m_axis_tdata,   // read_data
    output logic [3:0]         m_axis_tuser    // status, is_full, is_empty
);

    localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    logic [DEPTH_W-1:0]   depth_reg;
    logic                 accept;
    logic [IDX_W-1:0]     head_idx;
    logic [IDX_W-1:0]     tail_idx;
    ctrl_res_t            res;
    logic [WORD_BITS-1:0] wr_word;
    logic [WORD_BITS-1:0] chain [MAX_DEPTH+1];
    logic [DATA_W+WORD_BITS-1:0] wr_ext;
    logic [DATA_W+WORD_BITS-1:0] rd_ext;
    logic [DATA_W-1:0]    rd_word;
    logic [DATA_W-1:0]    res_data;
    logic [3:0]           res_user;

    logic                 out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]    out_data_reg, out_data_next;
    logic [3:0]           out_user_reg, out_user_next;
    logic                 skid_valid_reg, skid_valid_next;
    logic [DATA_W-1:0]    skid_data_reg, skid_data_next;
    logic [3:0]           skid_user_reg, skid_user_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= DEPTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            depth_reg <= cfg_wr_data;
        end
    end

    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    cfpl_ctrl #(
        .MAX_DEPTH (MAX_DEPTH),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .action    (s_axis_tuser),
        .depth_cfg (depth_reg),
        .head_idx  (head_idx),
        .tail_idx  (tail_idx),
        .res       (res)
    );

    assign wr_ext  = {{WORD_BITS{1'b0}}, s_axis_tdata};
    assign wr_word = wr_ext[WORD_BITS-1:0];
    assign chain[0] = '0;

    for (genvar i = 0; i < MAX_DEPTH; i++)
    begin : g_cell
        cfpl_cell #(
            .WORD_BITS (WORD_BITS),
            .IDX_W     (IDX_W),
            .CELL_IDX  (i)
        ) u_cell (
            .clk     (clk),
            .wr_en   (accept && res.do_write),
            .wr_idx  (head_idx),
            .wr_word (wr_word),
            .rd_idx  (tail_idx),
            .rd_in   (chain[i]),
            .rd_out  (chain[i+1])
        );
    end

    assign rd_ext   = {{DATA_W{1'b0}}, chain[MAX_DEPTH]};
    assign rd_word  = rd_ext[DATA_W-1:0];
    assign res_data = res.do_read ? rd_word : '0;
    assign res_user = {res.is_empty, res.is_full, res.status};

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_user_next  = skid_user_reg;
        if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                out_user_next   = skid_user_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = accept;
                out_data_next  = res_data;
                out_user_next  = res_user;
            end
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res_data;
            skid_user_next  = res_user;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        out_user_reg  <= out_user_next;
        skid_data_reg <= skid_data_next;
        skid_user_reg <= skid_user_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

// ===== hdl/cfpl_checker.sv =====
// ----------------------------------------------------------------------------
// cfpl_checker
// port-level checks on the result stream and the input stall, bound to the top level
// ----------------------------------------------------------------------------
`include "circular_fifo_with_pop_last_defines.svh"

module cfpl_checker
    import cfpl_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [DATA_W-1:0] m_axis_tdata,
    input logic [3:0]        m_axis_tuser
);

    `CFPL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `CFPL_ASSERT_NOW(a_flags_excl, m_axis_tvalid, !(m_axis_tuser[2] && m_axis_tuser[3]))
    `CFPL_ASSERT_NOW(a_full_status, m_axis_tvalid && (m_axis_tuser[1:0] == STAT_FULL), m_axis_tuser[2])
    `CFPL_ASSERT_NOW(a_empty_status, m_axis_tvalid && (m_axis_tuser[1:0] == STAT_EMPTY), m_axis_tuser[3] && (m_axis_tdata == '0))
    `CFPL_ASSERT_NOW(a_stall_cause, !s_axis_tready, m_axis_tvalid)

endmodule

bind circular_fifo_with_pop_last cfpl_checker u_cfpl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== verif/circular_fifo_with_pop_last_test.sv =====
// ----------------------------------------------------------------------------
// circular_fifo_with_pop_last_test
// directed table of corner cases, then random push, pop and delete-last
// stretches at several depths, each result checked against a local ring model or a typed row
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module circular_fifo_with_pop_last_test
    import cfpl_pkg::*;
();

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int RING_SLOTS = MAX_DEPTH_DEF;

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] read_data;
        logic              is_full;
        logic              is_empty;
    } fifo_result_t;

    typedef struct packed {
        logic               is_cfg;
        logic [DEPTH_W-1:0] depth;
        logic [1:0]         act;
        logic [DATA_W-1:0]  data;
        logic               typed;
        fifo_result_t       res;
    } stim_row_t;

    localparam fifo_result_t BY_MODEL = '0;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [DEPTH_W-1:0] cfg_wr_data;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [DATA_W-1:0]  s_axis_tdata;   // write_data
    logic [1:0]         s_axis_tuser;   // action
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [DATA_W-1:0]  m_axis_tdata;   // read_data
    logic [3:0]         m_axis_tuser;   // status, is_full, is_empty

    // local copy of the ring
    logic [DATA_W-1:0]  ring_words [RING_SLOTS];
    logic [RING_SLOTS-1:0] written_mask;
    logic [3:0]         head_ptr;
    logic [3:0]         tail_ptr;
    logic               full_now;
    logic               empty_now;
    logic [DEPTH_W-1:0] depth_sel;

    fifo_result_t pending_results [$];
    int           error_count = 0;
    int           results_seen = 0;
    logic         sender_calm;

    stim_row_t directed_rows [29] = '{
        '{1'b0, 5'd0,  ACT_READ,   32'h0000_0000, 1'b1, '{STAT_EMPTY, 32'h0, 1'b0, 1'b1}},
        '{1'b0, 5'd0,  ACT_DELETE, 32'h0000_0000, 1'b1, '{STAT_EMPTY, 32'h0, 1'b0, 1'b1}},
        '{1'b0, 5'd0,  ACT_UNUSED, 32'hFFFF_FFFF, 1'b1, '{STAT_DONE, 32'h0, 1'b0, 1'b1}},
        '{1'b0, 5'd0,  ACT_WRITE,  32'hFFFF_FFFF, 1'b1, '{STAT_DONE, 32'h0, 1'b0, 1'b0}},
        '{1'b0, 5'd0,  ACT_WRITE,  32'h0000_0000, 1'b0, BY_MODEL},
        '{1'b0, 5'd0,  ACT_READ,   32'h0000_0000, 1'b1,
            '{STAT_DONE, 32'hFFFF_FFFF, 1'b0, 1'b0}},
        '{1'b0, 5'd0,  ACT_DELETE, 32'h0000_0000, 1'b1, '{STAT_DONE, 32'h0, 1'b0, 1'b1}},
        // depth shrinks below the pointers
        '{1'b1, 5'd1,  ACT_WRITE,  32'h0000_0000, 1'b0, BY_MODEL},
        '{1'b0, 5'd0,  ACT_WRITE,  32'hA5A5_A5A5, 1'b0, BY_MODEL},
        '{1'b0, 5'd0,  ACT_WRITE,  32'h5A5A_5A5A, 1'b0, BY_MODEL},
        '{1'b0, 5'd0,  ACT_READ,   32'h0000_0000, 1'b0, BY_MODEL},
        '{1'b0, 5'd0,  ACT_WRITE,  32'h1234_5678, 1'b0, BY_MODEL},
        '{1'b0, 5'd0,  ACT_WRITE,  32'h0000_0000, 1'b1, '{STAT_FULL, 32'h0, 1'b1, 1'b0}},
        '{1'b0, 5'd0,  ACT_DELETE, 32'h0000_0000, 1'b0, BY_MODEL},
        // zero depth acts as one
        '{1'b1, 5'd0,  ACT_WRITE,  32'h0000_0000, 1'b0, BY_MODEL},
        '{1'b0, 5'd0,  ACT_WRITE,  32'hDEAD_BEEF, 1'b0, BY_MODEL},
        '{1'b0, 5'd0,  ACT_READ,   32'h0000_0000, 1'b0, BY_MODEL},
        // oversized depth acts as the full store
        '{1'b1, 5'd31, ACT_WRITE,  32'h0000_0000, 1'b0, BY_MODEL},
        '{1'b0, 5'd0,  ACT_WRITE,  32'h8000_0000, 1'b0, BY_MODEL},
        '{1'b0, 5'd0,  ACT_WRITE,  32'h0000_0001, 1'b0, BY_MODEL},
        '{1'b0, 5'd0,  ACT_DELETE, 32'h0000_0000, 1'b0, BY_MODEL},
        '{1'b0, 5'd0,  ACT_READ,   32'h0000_0000, 1'b0, BY_MODEL},
        '{1'b1, 5'd2,  ACT_WRITE,  32'h0000_0000, 1'b0, BY_MODEL},
        '{1'b0, 5'd0,  ACT_WRITE,  32'h0F0F_0F0F, 1'b0, BY_MODEL},
        '{1'b0, 5'd0,  ACT_WRITE,  32'hF0F0_F0F0, 1'b0, BY_MODEL},
        '{1'b0, 5'd0,  ACT_WRITE,  32'h0000_0000, 1'b1, '{STAT_FULL, 32'h0, 1'b1, 1'b0}},
        '{1'b0, 5'd0,  ACT_READ,   32'h0000_0000, 1'b0, BY_MODEL},
        '{1'b0, 5'd0,  ACT_READ,   32'h0000_0000, 1'b0, BY_MODEL},
        '{1'b0, 5'd0,  ACT_READ,   32'h0000_0000, 1'b1, '{STAT_EMPTY, 32'h0, 1'b0, 1'b1}}
    };

    circular_fifo_with_pop_last dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 clk = ~clk;

    function automatic logic [3:0] ring_advance(input logic [3:0] idx, input logic [4:0] d);
        logic [4:0] nxt;
        nxt = {1'b0, idx} + 5'd1;
        return (nxt >= d) ? 4'd0 : nxt[3:0];
    endfunction

    function automatic fifo_result_t apply_action(input logic [1:0] act,
                                                  input logic [DATA_W-1:0] data);
        fifo_result_t res;
        logic [4:0]   d;
        logic [4:0]   back;
        res = '0;
        d = (depth_sel == 5'd0) ? 5'd1 :
            (depth_sel > RING_SLOTS) ? 5'(RING_SLOTS) : depth_sel;
        case (act)
            ACT_WRITE:
            begin
                if (head_ptr == tail_ptr && !empty_now)
                begin
                    res.status = STAT_FULL;
                end
                else
                begin
                    ring_words[head_ptr] = data;
                    written_mask[head_ptr] = 1'b1;
                    head_ptr = ring_advance(head_ptr, d);
                    if (head_ptr == tail_ptr)
                        full_now = 1'b1;
                    empty_now = 1'b0;
                end
            end
            ACT_READ:
            begin
                if (head_ptr == tail_ptr && !full_now)
                begin
                    res.status = STAT_EMPTY;
                end
                else
                begin
                    res.read_data = ring_words[tail_ptr];
                    tail_ptr = ring_advance(tail_ptr, d);
                    if (head_ptr == tail_ptr)
                        empty_now = 1'b1;
                    full_now = 1'b0;
                end
            end
            ACT_DELETE:
            begin
                if (head_ptr == tail_ptr && !full_now)
                begin
                    res.status = STAT_EMPTY;
                end
                else
                begin
                    back = (head_ptr == 4'd0) ? d - 5'd1 : {1'b0, head_ptr} - 5'd1;
                    if (back >= d)
                        back = d - 5'd1;
                    head_ptr = back[3:0];
                    if (head_ptr == tail_ptr)
                        empty_now = 1'b1;
                    full_now = 1'b0;
                end
            end
            default:
            begin
                res.status = STAT_DONE;
            end
        endcase
        res.is_full = full_now;
        res.is_empty = empty_now;
        return res;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input logic [1:0] act, input logic [DATA_W-1:0] data,
                             input logic typed, input fifo_result_t typed_res);
        fifo_result_t predicted;
        while (!sender_calm && $urandom_range(0, 99) < 15)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= data;
        do @(posedge clk); while (!s_axis_tready);
        predicted = apply_action(act, data);
        pending_results.push_back(typed ? typed_res : predicted);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic set_depth(input logic [DEPTH_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        depth_sel = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin : check_results
        fifo_result_t want;
        fifo_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen = results_seen + 1;
            got = '{m_axis_tuser[1:0], m_axis_tdata, m_axis_tuser[2], m_axis_tuser[3]};
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, got %h", $time, got);
                error_count = error_count + 1;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                begin
                    $display("%0t: status expected %0d got %0d", $time,
                             want.status, got.status);
                    error_count = error_count + 1;
                end
                if (got.read_data !== want.read_data)
                begin
                    $display("%0t: read_data expected %h got %h", $time,
                             want.read_data, got.read_data);
                    error_count = error_count + 1;
                end
                if (got.is_full !== want.is_full)
                begin
                    $display("%0t: is_full expected %b got %b", $time,
                             want.is_full, got.is_full);
                    error_count = error_count + 1;
                end
                if (got.is_empty !== want.is_empty)
                begin
                    $display("%0t: is_empty expected %b got %b", $time,
                             want.is_empty, got.is_empty);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // receiver: random stalls, one long hold-off, one calm window
    initial
    begin
        logic held;
        held = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && results_seen >= 330)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (80) @(negedge clk);
            end
            m_axis_tready <= (results_seen >= 500 && results_seen < 650) ||
                             ($urandom_range(0, 99) >= 15);
        end
    end

    initial
    begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int          item_count;
        int          mode_left;
        int          write_lim;
        int          read_lim;
        int          roll;
        logic [1:0]  act;
        logic [31:0] data;
        logic [4:0]  phase_depth;

        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = ACT_WRITE;
        sender_calm = 1'b0;
        head_ptr = '0;
        tail_ptr = '0;
        full_now = 1'b0;
        empty_now = 1'b1;
        depth_sel = DEPTH_RESET;
        written_mask = '0;
        item_count = 0;
        mode_left = 0;
        write_lim = 45;
        read_lim = 85;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                set_depth(directed_rows[i].depth);
            else
                send_item(directed_rows[i].act, directed_rows[i].data,
                          directed_rows[i].typed, directed_rows[i].res);
        end

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: phase_depth = 5'd16;
                1: phase_depth = 5'd1;
                2: phase_depth = 5'd4;
                3: phase_depth = 5'($urandom_range(2, 15));
                4: phase_depth = 5'd16;
                default: phase_depth = 5'($urandom_range(1, 16));
            endcase
            set_depth(phase_depth);
            for (int i = 0; i < 125; i++)
            begin
                // fill-heavy, drain-heavy or balanced stretches
                if (mode_left == 0)
                begin
                    mode_left = $urandom_range(10, 50);
                    case ($urandom_range(0, 2))
                        0: begin write_lim = 70; read_lim = 85; end
                        1: begin write_lim = 15; read_lim = 85; end
                        default: begin write_lim = 45; read_lim = 85; end
                    endcase
                end
                mode_left = mode_left - 1;
                roll = $urandom_range(0, 99);
                if (roll < write_lim)
                    act = ACT_WRITE;
                else if (roll < read_lim)
                    act = ACT_READ;
                else if (roll < 96)
                    act = ACT_DELETE;
                else
                    act = ACT_UNUSED;
                // never pop a slot that was never written
                if (act == ACT_READ && !(head_ptr == tail_ptr && !full_now) &&
                    !written_mask[tail_ptr])
                    act = ACT_WRITE;
                case ($urandom_range(0, 9))
                    0: data = 32'h0000_0000;
                    1: data = 32'hFFFF_FFFF;
                    default: data = $urandom;
                endcase
                sender_calm = (item_count >= 300 && item_count < 450);
                send_item(act, data, 1'b0, BY_MODEL);
                item_count = item_count + 1;
            end
        end

        s_axis_tvalid <= 1'b0;
        wait_idle();
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/cfpl_pkg.sv
hdl/cfpl_cell.sv
hdl/cfpl_ctrl.sv
hdl/circular_fifo_with_pop_last.sv
hdl/cfpl_checker.sv
verif/circular_fifo_with_pop_last_test.sv
